FILE: hdl/assert_macros.svh
// Assertion helpers, clocked on clock and quiet while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(lbl, a, b, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (a) |-> (b)) else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, a, b, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (a) |=> (b)) else $error(msg);

`endif

FILE: hdl/sti_pkg.sv
package sti_pkg;

   // Request codes
   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_LOOKUP = 1'b1;

   // Response status codes
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_FULL    = 2'd1;
   localparam logic [1:0] ST_MISSING = 2'd2;

   // Result selection codes, controller to datapath
   localparam logic [1:0] RES_INSERTED = 2'd0;
   localparam logic [1:0] RES_FULL     = 2'd1;
   localparam logic [1:0] RES_FOUND    = 2'd2;
   localparam logic [1:0] RES_MISSING  = 2'd3;

   typedef struct packed {
      logic               req_type;
      logic signed [31:0] key;
   } req_item_type;

   typedef struct packed {
      logic [1:0] status;
      logic [5:0] slot;
      logic [6:0] entries;
   } rsp_item_type;

   typedef struct packed {
      logic       start;      // capture request, seed search bounds
      logic       rd_mid;     // read table at search midpoint
      logic       rd_prev;    // read table at pos - 1
      logic       srch_step;  // narrow search range from last compare
      logic       shift_wr;   // move read entry up to pos, pos--
      logic       key_wr;     // write key at pos, count++
      logic       result_ld;  // load response register
      logic [1:0] res_sel;
   } cmd_type;

   typedef struct packed {
      logic is_lookup;
      logic full;
      logic range_empty;
      logic pos_zero;
      logic key_lt_rd;
      logic key_gt_rd;
      logic out_free;
   } sts_type;

endpackage

FILE: hdl/sti_ctrl.sv
module sti_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  sti_pkg::sts_type sts,
   output sti_pkg::cmd_type cmd
);
   import sti_pkg::*;

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_DISPATCH = 3'd1;
   localparam logic [2:0] S_INS_RD   = 3'd2;
   localparam logic [2:0] S_INS_CMP  = 3'd3;
   localparam logic [2:0] S_SRCH_RD  = 3'd4;
   localparam logic [2:0] S_SRCH_CMP = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            if (sts.is_lookup) begin
               state_in = S_SRCH_RD;
            end else if (sts.full) begin
               if (sts.out_free) begin
                  cmd.result_ld = 1'b1;
                  cmd.res_sel   = RES_FULL;
                  state_in      = S_IDLE;
               end
            end else begin
               state_in = S_INS_RD;
            end
         end
         S_INS_RD: begin
            if (sts.pos_zero) begin
               if (sts.out_free) begin
                  cmd.key_wr    = 1'b1;
                  cmd.result_ld = 1'b1;
                  cmd.res_sel   = RES_INSERTED;
                  state_in      = S_IDLE;
               end
            end else begin
               cmd.rd_prev = 1'b1;
               state_in    = S_INS_CMP;
            end
         end
         S_INS_CMP: begin
            if (sts.key_lt_rd) begin
               cmd.shift_wr = 1'b1;
               state_in     = S_INS_RD;
            end else if (sts.out_free) begin
               cmd.key_wr    = 1'b1;
               cmd.result_ld = 1'b1;
               cmd.res_sel   = RES_INSERTED;
               state_in      = S_IDLE;
            end
         end
         S_SRCH_RD: begin
            if (sts.range_empty) begin
               if (sts.out_free) begin
                  cmd.result_ld = 1'b1;
                  cmd.res_sel   = RES_MISSING;
                  state_in      = S_IDLE;
               end
            end else begin
               cmd.rd_mid = 1'b1;
               state_in   = S_SRCH_CMP;
            end
         end
         S_SRCH_CMP: begin
            if (sts.key_lt_rd || sts.key_gt_rd) begin
               cmd.srch_step = 1'b1;
               state_in      = S_SRCH_RD;
            end else if (sts.out_free) begin
               cmd.result_ld = 1'b1;
               cmd.res_sel   = RES_FOUND;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: hdl/sti_dpath.sv
module sti_dpath #(
   parameter int TABLE_DEPTH = 64,
   parameter int AW = $clog2(TABLE_DEPTH),
   parameter int CW = $clog2(TABLE_DEPTH + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  sti_pkg::req_item_type req_data,
   input  sti_pkg::cmd_type      cmd,
   output sti_pkg::sts_type      sts,
   output logic [CW-1:0]         count,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output sti_pkg::rsp_item_type rsp_data
);
   import sti_pkg::*;

   logic signed [31:0] key_store_ff [TABLE_DEPTH];

   logic               type_ff;
   logic signed [31:0] key_ff;
   logic signed [31:0] rd_data_ff;
   logic [CW-1:0]      count_ff;
   logic [CW-1:0]      lo_ff;
   logic [CW-1:0]      hi_ff;     // exclusive upper bound
   logic [CW-1:0]      pos_ff;
   logic               rsp_valid_ff;
   rsp_item_type       rsp_data_ff;
   rsp_item_type       rsp_data_in;

   logic [CW:0]        mid_sum;
   logic [CW-1:0]      mid;
   logic [CW-1:0]      pos_m1;
   logic               rd_en;
   logic [AW-1:0]      rd_addr;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic signed [31:0] wr_data;

   // floor((lo + hi_incl) / 2) with hi_incl = hi - 1; only used when lo < hi
   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff} - {{CW{1'b0}}, 1'b1};
   assign mid     = mid_sum[CW:1];
   assign pos_m1  = pos_ff - {{(CW-1){1'b0}}, 1'b1};

   assign rd_en   = cmd.rd_mid | cmd.rd_prev;
   assign rd_addr = cmd.rd_mid ? mid[AW-1:0] : pos_m1[AW-1:0];
   assign wr_en   = cmd.shift_wr | cmd.key_wr;
   assign wr_addr = pos_ff[AW-1:0];
   assign wr_data = cmd.shift_wr ? rd_data_ff : key_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_store_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= key_store_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         type_ff <= req_data.req_type;
         key_ff  <= req_data.key;
         lo_ff   <= '0;
         hi_ff   <= count_ff;
         pos_ff  <= count_ff;
      end else begin
         if (cmd.srch_step) begin
            if (key_ff > rd_data_ff) begin
               lo_ff <= mid + {{(CW-1){1'b0}}, 1'b1};
            end else begin
               hi_ff <= mid;
            end
         end
         if (cmd.shift_wr) begin
            pos_ff <= pos_m1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.key_wr) begin
         count_ff <= count_ff + {{(CW-1){1'b0}}, 1'b1};
      end
   end

   always_comb begin
      rsp_data_in = '0;
      case (cmd.res_sel)
         RES_INSERTED: begin
            rsp_data_in.status  = ST_OK;
            rsp_data_in.slot    = 6'(pos_ff);
            rsp_data_in.entries = 7'(count_ff + {{(CW-1){1'b0}}, 1'b1});
         end
         RES_FULL: begin
            rsp_data_in.status  = ST_FULL;
            rsp_data_in.entries = 7'(count_ff);
         end
         RES_FOUND: begin
            rsp_data_in.status  = ST_OK;
            rsp_data_in.slot    = 6'(mid);
            rsp_data_in.entries = 7'(count_ff);
         end
         default: begin
            rsp_data_in.status  = ST_MISSING;
            rsp_data_in.entries = 7'(count_ff);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.result_ld) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.result_ld) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign sts.is_lookup   = (type_ff == REQ_LOOKUP);
   assign sts.full        = (count_ff == CW'(TABLE_DEPTH));
   assign sts.range_empty = (lo_ff >= hi_ff);
   assign sts.pos_zero    = (pos_ff == '0);
   assign sts.key_lt_rd   = (key_ff < rd_data_ff);
   assign sts.key_gt_rd   = (key_ff > rd_data_ff);
   assign sts.out_free    = !rsp_valid_ff || !rsp_stall;

   assign count     = count_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: hdl/sorted_table_insert_search.sv
// Lookup makes P table probes, P <= ceil(log2(N+1)), N = keys held; an insert
//   shifts the S larger entries up one slot each before writing its key; an insert
//   into a full table only returns the full status. A stalled response output delays the result.
// Throughput: one request in flight; the next is taken the cycle after the response loads.
// Reset: synchronous, clears the key count, controller and response valid;
//   the key table is not cleared (entries past the count are never read).
module sorted_table_insert_search #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  sti_pkg::req_item_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output sti_pkg::rsp_item_type rsp_data
);
   import sti_pkg::*;

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   cmd_type       cmd;
   sts_type       sts;
   logic [CW-1:0] dp_count;

   // Controller: sequences insert (find slot by walking down, shifting larger
   // keys up one at a time, each after a registered table read) and lookup
   // (binary search, each probe waiting on the registered table read).
   sti_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Datapath: key table memory, search bounds, insert pointer, count and
   // the response register that decouples the result channel.
   sti_dpath #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .AW          (AW),
      .CW          (CW)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .count     (dp_count),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

`include "assert_macros.svh"

   // Key count never exceeds table depth.
   `ASSERT_IMPLIES(a_count_max, 1'b1, dp_count <= CW'(TABLE_DEPTH), "count past depth")

   // Count only holds or grows by one per cycle.
   `ASSERT_NEXT(a_count_step, 1'b1, (dp_count - $past(dp_count)) <= CW'(1), "count jump")

   // One request at a time: an accepted transfer stalls the input next cycle.
   `ASSERT_NEXT(a_one_inflight, req_valid && !req_stall, req_stall, "second request taken")

   // A result loads only when the response register is free or draining.
   `ASSERT_IMPLIES(a_load_free, cmd.result_ld, !rsp_valid || !rsp_stall, "response overwritten")

endmodule
